// File: src/upd_pkg.sv
// Package for the URL percent decoder: character constants and hex digit helpers.
package upd_pkg;

  // The escape character.
  localparam logic [7:0] PctChar = 8'h25;

  // Largest number of decoded bytes that one item can give.
  localparam int unsigned MaxRun = 3;
  localparam int unsigned RunCntW = $clog2(MaxRun + 1);

  typedef logic [RunCntW-1:0] run_cnt_t;
  typedef logic [7:0] byte_t;

  // True when the byte is a hex digit in either case.
  function automatic logic hex_ok(input byte_t b);
    logic is_num;
    logic is_upper;
    logic is_lower;
    is_num   = (b >= 8'h30) && (b <= 8'h39);
    is_upper = (b >= 8'h41) && (b <= 8'h46);
    is_lower = (b >= 8'h61) && (b <= 8'h66);
    return is_num || is_upper || is_lower;
  endfunction

  // Value of a hex digit. The result means nothing for other bytes.
  function automatic logic [3:0] hex_val(input byte_t b);
    logic [3:0] v;
    if (b <= 8'h39) begin
      v = b[3:0];
    end else begin
      v = b[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

// File: src/url_percent_decoder_unit.sv
// URL percent decoder: turns an encoded byte stream into decoded bytes, one item per byte.
// Latency: an item's first decoded byte is offered in the cycle after the item is accepted.
// Throughput: one item per cycle while each item gives at most one byte and the output
// is not stalled; an item that gives a run of two or three bytes holds off the next item
// until its run has drained, which is set by the single output port of the result buffer.
// Reset: rst_ni clears the escape state and empties the result buffer.
module url_percent_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Encoded byte channel.
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_in_i,
  // Decoded byte channel.
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       message_end_o
);

  // Escape state. A '%' has been seen while pend_q is set; held_q says whether the
  // byte after it is already kept in hbyte_q, waiting for the second digit.
  logic              pend_q, pend_d;
  logic              held_q, held_d;
  upd_pkg::byte_t    hbyte_q, hbyte_d;

  // Result buffer. It holds the bytes that one item gives, the one at the front
  // being offered on the output. rcnt_q counts the bytes still to go.
  upd_pkg::byte_t    rbuf_q [upd_pkg::MaxRun];
  upd_pkg::byte_t    rbuf_d [upd_pkg::MaxRun];
  upd_pkg::run_cnt_t rcnt_q, rcnt_d;
  logic              rlast_q, rlast_d;

  // Bytes given by the item on the input, worked out in one pass.
  upd_pkg::byte_t    emit [upd_pkg::MaxRun];
  upd_pkg::run_cnt_t emit_cnt;

  logic in_acc;
  logic out_acc;

  // The buffer can take a new item once it is empty, or once its final byte leaves
  // in this cycle. The output valid only looks at the buffer count.
  assign in_stall_o = (rcnt_q > upd_pkg::run_cnt_t'(1)) ||
                      ((rcnt_q == upd_pkg::run_cnt_t'(1)) && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign out_valid_o   = (rcnt_q != '0);
  assign out_acc       = out_valid_o && !out_stall_i;
  assign out_byte_o    = rbuf_q[0];
  assign run_end_o     = (rcnt_q == upd_pkg::run_cnt_t'(1));
  assign message_end_o = run_end_o && rlast_q;

  // Decode one item against the escape state.
  always_comb begin
    for (int i = 0; i < upd_pkg::MaxRun; i++) begin
      emit[i] = '0;
    end
    emit_cnt = '0;
    pend_d   = pend_q;
    held_d   = held_q;
    hbyte_d  = hbyte_q;

    if (pend_q && held_q) begin
      // Second byte after a '%': the escape resolves one way or the other.
      pend_d = 1'b0;
      held_d = 1'b0;
      if (upd_pkg::hex_ok(hbyte_q) && upd_pkg::hex_ok(in_byte_i)) begin
        emit[0]  = {upd_pkg::hex_val(hbyte_q), upd_pkg::hex_val(in_byte_i)};
        emit_cnt = upd_pkg::run_cnt_t'(1);
      end else begin
        // Not a valid escape: give the '%' and run both bytes through again.
        emit[0]  = upd_pkg::PctChar;
        emit_cnt = upd_pkg::run_cnt_t'(1);
        if (hbyte_q == upd_pkg::PctChar) begin
          // The held byte opens a fresh escape, and this byte follows it.
          if (last_in_i) begin
            emit[1]  = upd_pkg::PctChar;
            emit_cnt = upd_pkg::run_cnt_t'(2);
          end else begin
            pend_d  = 1'b1;
            held_d  = 1'b1;
            hbyte_d = in_byte_i;
          end
        end else begin
          emit[1]  = hbyte_q;
          emit_cnt = upd_pkg::run_cnt_t'(2);
          if (in_byte_i == upd_pkg::PctChar) begin
            if (last_in_i) begin
              emit[2]  = upd_pkg::PctChar;
              emit_cnt = upd_pkg::run_cnt_t'(3);
            end else begin
              pend_d = 1'b1;
            end
          end else begin
            emit[2]  = in_byte_i;
            emit_cnt = upd_pkg::run_cnt_t'(3);
          end
        end
      end
    end else if (pend_q) begin
      // First byte after a '%': keep it, unless the message ends here.
      if (last_in_i) begin
        emit[0]  = upd_pkg::PctChar;
        emit_cnt = upd_pkg::run_cnt_t'(1);
      end else begin
        hbyte_d = in_byte_i;
        held_d  = 1'b1;
      end
    end else if (in_byte_i == upd_pkg::PctChar) begin
      if (last_in_i) begin
        emit[0]  = upd_pkg::PctChar;
        emit_cnt = upd_pkg::run_cnt_t'(1);
      end else begin
        pend_d = 1'b1;
        held_d = 1'b0;
      end
    end else begin
      emit[0]  = in_byte_i;
      emit_cnt = upd_pkg::run_cnt_t'(1);
    end

    // The end of a message always leaves the escape state clear.
    if (last_in_i) begin
      pend_d  = 1'b0;
      held_d  = 1'b0;
      hbyte_d = '0;
    end
  end

  // Next contents of the result buffer: load a new run, or move the run on by one.
  always_comb begin
    rbuf_d  = rbuf_q;
    rcnt_d  = rcnt_q;
    rlast_d = rlast_q;
    if (in_acc) begin
      rbuf_d  = emit;
      rcnt_d  = emit_cnt;
      rlast_d = last_in_i;
    end else if (out_acc) begin
      for (int i = 0; i < upd_pkg::MaxRun - 1; i++) begin
        rbuf_d[i] = rbuf_q[i+1];
      end
      rbuf_d[upd_pkg::MaxRun-1] = '0;
      rcnt_d = rcnt_q - upd_pkg::run_cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      held_q  <= 1'b0;
      hbyte_q <= '0;
      rcnt_q  <= '0;
      rlast_q <= 1'b0;
    end else begin
      if (in_acc) begin
        pend_q  <= pend_d;
        held_q  <= held_d;
        hbyte_q <= hbyte_d;
      end
      rcnt_q  <= rcnt_d;
      rlast_q <= rlast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rbuf_q <= rbuf_d;
  end

  // A byte can only be held while an escape is open.
  a_held_needs_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> pend_q)
    else $error("held byte without an open escape");

  // The final item of a message always gives at least one byte.
  a_last_gives_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_in_i) |=> out_valid_o)
    else $error("final item gave no result");

  // The final item of a message leaves no escape open.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_in_i) |=> (!pend_q && !held_q))
    else $error("escape state survived the end of a message");

  // The second byte after a '%' always resolves the escape with output.
  a_escape_resolves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pend_q && held_q) |=> out_valid_o)
    else $error("resolved escape gave no result");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the URL percent decoder: directed, random and back-pressure tests.
module testbench;

  // One decoded byte as it should leave the block.
  typedef struct packed {
    upd_pkg::byte_t data;
    logic           run_end;
    logic           msg_end;
  } decoded_t;

  localparam upd_pkg::byte_t Ch0 = "0";
  localparam upd_pkg::byte_t Ch9 = "9";
  localparam upd_pkg::byte_t ChUpA = "A";
  localparam upd_pkg::byte_t ChUpF = "F";
  localparam upd_pkg::byte_t ChLoA = "a";
  localparam upd_pkg::byte_t ChLoF = "f";
  localparam int unsigned TenDigit = 10;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  upd_pkg::byte_t in_byte_i = '0;
  logic           last_in_i = 1'b0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  upd_pkg::byte_t out_byte_o;
  logic           run_end_o;
  logic           message_end_o;

  url_percent_decoder_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .last_in_i     (last_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .run_end_o     (run_end_o),
    .message_end_o (message_end_o)
  );

  always #4 clk_i = ~clk_i;

  // Predicted escape state, kept in step with every accepted item.
  logic           esc_open = 1'b0;
  logic           esc_held = 1'b0;
  upd_pkg::byte_t esc_held_byte = '0;
  upd_pkg::byte_t run_bytes[$];
  decoded_t       expected_bytes[$];

  int err_cnt = 0;
  int item_cnt = 0;
  int result_cnt = 0;
  int msg_cnt = 0;

  // Sender and receiver pacing.
  logic  bursty = 1'b1;
  int    burst_left = 0;
  logic  stall_on = 1'b0;
  logic  hold_req = 1'b0;
  int    hold_len = 0;
  int    hold_left = 0;
  int    stretch_left = 0;
  int    stall_pct = 0;

  string hex_chars = "0123456789ABCDEFabcdef";
  string near_hex = "/:@G`g";

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Returns 1 and the digit value when the byte is a hex digit in either case.
  function automatic logic decode_hex(input upd_pkg::byte_t b, output logic [3:0] v);
    v = '0;
    if (b >= Ch0 && b <= Ch9) begin
      v = 4'(b - Ch0);
      return 1'b1;
    end
    if (b >= ChUpA && b <= ChUpF) begin
      v = 4'(b - ChUpA + TenDigit);
      return 1'b1;
    end
    if (b >= ChLoA && b <= ChLoF) begin
      v = 4'(b - ChLoA + TenDigit);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // One byte seen while nothing is held after an escape character.
  function automatic void decode_plain(input upd_pkg::byte_t b, input logic last);
    if (esc_open) begin
      if (last) begin
        run_bytes.push_back(upd_pkg::PctChar);
        esc_open = 1'b0;
        esc_held = 1'b0;
      end else begin
        esc_held_byte = b;
        esc_held = 1'b1;
      end
    end else if (b == upd_pkg::PctChar) begin
      if (last) begin
        run_bytes.push_back(upd_pkg::PctChar);
      end else begin
        esc_open = 1'b1;
        esc_held = 1'b0;
      end
    end else begin
      run_bytes.push_back(b);
    end
  endfunction

  // Works out the decoded run of one accepted item and queues it.
  function automatic void decode_item(input upd_pkg::byte_t b, input logic last);
    upd_pkg::byte_t first;
    logic [3:0]     hi;
    logic [3:0]     lo;
    logic           hi_ok;
    logic           lo_ok;
    decoded_t       r;
    run_bytes.delete();
    if (esc_open && esc_held) begin
      first = esc_held_byte;
      hi_ok = decode_hex(first, hi);
      lo_ok = decode_hex(b, lo);
      esc_open = 1'b0;
      esc_held = 1'b0;
      esc_held_byte = '0;
      if (hi_ok && lo_ok) begin
        run_bytes.push_back({hi, lo});
      end else begin
        // A failed escape gives the escape character, then both bytes go round again.
        run_bytes.push_back(upd_pkg::PctChar);
        decode_plain(first, 1'b0);
        decode_plain(b, last);
      end
    end else begin
      decode_plain(b, last);
    end
    if (last) begin
      esc_open = 1'b0;
      esc_held = 1'b0;
      esc_held_byte = '0;
    end
    foreach (run_bytes[k]) begin
      r.data = run_bytes[k];
      r.run_end = (k == run_bytes.size() - 1);
      r.msg_end = r.run_end && last;
      expected_bytes.push_back(r);
    end
  endfunction

  // Offers one item and waits until the block takes it. Gaps fall between bursts.
  task automatic send_item(input upd_pkg::byte_t b, input logic last);
    int gap;
    if (bursty && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    last_in_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    decode_item(b, last);
    item_cnt++;
    if (last) msg_cnt++;
  endtask

  // Drops valid and waits until every predicted byte has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_bytes.size() != 0);
  endtask

  task automatic send_message(input upd_pkg::byte_t msg[$]);
    foreach (msg[k]) send_item(msg[k], k == msg.size() - 1);
  endtask

  function automatic upd_pkg::byte_t pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return upd_pkg::PctChar;
    if (r < 50) return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
    if (r < 62) return near_hex[$urandom_range(0, near_hex.len() - 1)];
    return upd_pkg::byte_t'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed escapes with random content, cut at a random length so that
  // escapes also straddle the end of the message.
  function automatic void build_message(output upd_pkg::byte_t msg[$], input int len);
    msg.delete();
    while (msg.size() < len) begin
      if ($urandom_range(0, 99) < 40) begin
        msg.push_back(upd_pkg::PctChar);
        msg.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
        msg.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
      end else begin
        msg.push_back(pick_byte());
      end
    end
    while (msg.size() > len) void'(msg.pop_back());
  endfunction

  // Receiver: a long hold-off on request, otherwise stretches of random stall density,
  // some of them with no stalls at all.
  always @(posedge clk_i) begin : receiver_stall
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = hold_len - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(4, 40);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      stretch_left--;
      out_stall_i <= stall_on && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Each decoded byte taken from the block is held against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    decoded_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_cnt++;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_byte_o));
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte_o !== want.data)
          report_mismatch($sformatf("byte %02h, predicted %02h", out_byte_o, want.data));
        if (run_end_o !== want.run_end)
          report_mismatch($sformatf("run_end %b, predicted %b on byte %02h",
                                    run_end_o, want.run_end, want.data));
        if (message_end_o !== want.msg_end)
          report_mismatch($sformatf("message_end %b, predicted %b on byte %02h",
                                    message_end_o, want.msg_end, want.data));
      end
    end
  end

  // Field extremes, hex digits of both cases and their neighbours, failed escapes,
  // escape characters in a row, and escapes cut short by the end of a message.
  task automatic test_directed();
    send_message('{8'h00, 8'hFF});
    send_message('{upd_pkg::PctChar, "9", "F"});
    send_message('{upd_pkg::PctChar, "a", "0"});
    send_message('{upd_pkg::PctChar, "G", "/"});
    send_message('{upd_pkg::PctChar, upd_pkg::PctChar, "6", "1"});
    send_message('{upd_pkg::PctChar, ":"});
    send_message('{upd_pkg::PctChar});
    send_message('{upd_pkg::PctChar, "g", "@"});
    send_message('{upd_pkg::PctChar, upd_pkg::PctChar, upd_pkg::PctChar});
    send_message('{upd_pkg::PctChar, "G", upd_pkg::PctChar});
    wait_drained();
  endtask

  // Random messages, now and then with a pause until the output has caught up.
  task automatic test_random_messages(input int n_items);
    upd_pkg::byte_t msg[$];
    int             stop_at;
    stop_at = item_cnt + n_items;
    while (item_cnt < stop_at) begin
      build_message(msg, $urandom_range(1, 14));
      send_message(msg);
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while the sender offers back-to-back
  // failed escapes, most of which give a three-byte run, so the block has to stall.
  task automatic test_output_backlog();
    upd_pkg::byte_t msg[$];
    bursty = 1'b0;
    hold_len = 80;
    hold_req = 1'b1;
    msg.delete();
    repeat (10) begin
      msg.push_back(upd_pkg::PctChar);
      msg.push_back(near_hex[$urandom_range(0, near_hex.len() - 1)]);
      msg.push_back(pick_byte());
    end
    send_message(msg);
    wait_drained();
    bursty = 1'b1;
  endtask

  // Short messages, each followed by a pause until every predicted byte has come.
  task automatic test_sender_pause();
    upd_pkg::byte_t msg[$];
    repeat (6) begin
      build_message(msg, $urandom_range(1, 6));
      send_message(msg);
      wait_drained();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    stall_on = 1'b1;
    test_directed();
    test_random_messages(200);
    test_output_backlog();
    test_sender_pause();
    bursty = 1'b0;
    test_random_messages(170);
    stall_on = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d items in %0d messages, %0d decoded bytes checked.",
             item_cnt, msg_cnt, result_cnt);
    $display("Included failed escapes, truncated escapes, long output hold-off and drains.");
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
